// ===== hdl/gpp_pkg.sv =====
// Shared types and constants for the grid point projector.
// Field widths, configuration register indexes and reset values.
// No dependencies.
package gpp_pkg;

    localparam int COEF_W     = 16;
    localparam int LANES      = 4;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_CNT_W  = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int HEIGHT_W   = 16;
    localparam int PIX_W      = 10;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_X_COEF    = 2'd0,
        CFG_Y_COEF    = 2'd1,
        CFG_GRID_COLS = 2'd2,
        CFG_GRID_ROWS = 2'd3
    } cfg_index_t;

    localparam logic [CFG_DATA_W-1:0] X_COEF_RESET = 64'd256;
    localparam logic [CFG_DATA_W-1:0] Y_COEF_RESET = 64'd16777216;
    localparam logic [CFG_CNT_W-1:0]  COUNT_RESET  = 11'd1;

endpackage

// ===== hdl/grid_point_projector.sv =====
// Grid point projector: walks a height map grid and projects each point to
// screen coordinates through two columns of a camera matrix.
// Depends on gpp_pkg.
//
// Channel  Handshake              Payload
// in       in_valid / in_stall    height, first_of_frame
// out      out_valid / out_stall  pixel_x, pixel_y, visible, frame_end
// cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One item per cycle sustained while out_stall is low; grid counters and point
// setup feed the input stage registers, then eight parallel multiplies, the
// sums and the screen compare feed the result register.
// Reset returns the counters to zero and the configuration registers to their defaults.
// A stalled result holds the output register; the input stage still takes an
// item while it is empty, and in_stall rises only when both stages are full.
module grid_point_projector
    import gpp_pkg::*;
#(
    parameter int SCREEN_WIDTH       = 1024,
    parameter int SCREEN_HEIGHT      = 768,
    parameter int GRID_MAX           = 1024,
    parameter int COEF_FRACTION_BITS = 8
)
(
    input  logic                        clk,
    input  logic                        rst_n,

    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic signed [HEIGHT_W-1:0]  height,
    input  logic                        first_of_frame,

    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [PIX_W-1:0]            pixel_x,
    output logic [PIX_W-1:0]            pixel_y,
    output logic                        visible,
    output logic                        frame_end,

    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_data
);

    localparam int IDX_W  = $clog2(GRID_MAX);
    localparam int CNT_W  = $clog2(GRID_MAX + 1);
    localparam int EXT_W  = (CNT_W > CFG_CNT_W) ? CNT_W : CFG_CNT_W;
    localparam int P_W    = CNT_W + 2;
    localparam int PT_W   = (P_W > HEIGHT_W) ? P_W : HEIGHT_W;
    localparam int PROD_W = COEF_W + PT_W;
    localparam int SUM_W  = PROD_W + 2;

    localparam logic signed [SUM_W-1:0] W_LIM =
        SUM_W'(SCREEN_WIDTH * (2 ** COEF_FRACTION_BITS));
    localparam logic signed [SUM_W-1:0] H_LIM =
        SUM_W'(SCREEN_HEIGHT * (2 ** COEF_FRACTION_BITS));

    logic [CFG_DATA_W-1:0]       x_coef_reg;
    logic [CFG_DATA_W-1:0]       y_coef_reg;
    logic [CFG_CNT_W-1:0]        cols_reg;
    logic [CFG_CNT_W-1:0]        rows_reg;

    logic [IDX_W-1:0]            outer_reg, outer_next;
    logic [IDX_W-1:0]            inner_reg, inner_next;

    logic                        s1_valid_reg;
    logic signed [P_W-1:0]       s1_px_reg;
    logic signed [P_W-1:0]       s1_py_reg;
    logic signed [HEIGHT_W-1:0]  s1_h_reg;
    logic                        s1_last_reg;

    logic                        out_valid_reg;
    logic [PIX_W-1:0]            pixel_x_reg;
    logic [PIX_W-1:0]            pixel_y_reg;
    logic                        visible_reg;
    logic                        frame_end_reg;

    logic [CNT_W-1:0]            cols_eff;
    logic [CNT_W-1:0]            rows_eff;
    logic [IDX_W-1:0]            outer_cur;
    logic [IDX_W-1:0]            inner_cur;
    logic                        inner_wrap;
    logic                        outer_wrap;
    logic signed [P_W-1:0]       px;
    logic signed [P_W-1:0]       py;

    logic                        in_accept;
    logic                        out_free;
    logic                        s1_move;

    logic signed [PT_W-1:0]      pt [LANES];
    logic signed [COEF_W-1:0]    cx [LANES];
    logic signed [COEF_W-1:0]    cy [LANES];
    logic signed [PROD_W-1:0]    prod_x [LANES];
    logic signed [PROD_W-1:0]    prod_y [LANES];
    logic signed [SUM_W-1:0]     sum_x;
    logic signed [SUM_W-1:0]     sum_y;
    logic                        vis;

    function automatic logic [CNT_W-1:0] eff_count(input logic [CFG_CNT_W-1:0] v);
        logic [CNT_W-1:0] r;
        if (v == '0)
            r = CNT_W'(1);
        else if (EXT_W'(v) > EXT_W'(GRID_MAX))
            r = CNT_W'(GRID_MAX);
        else
            r = CNT_W'(v);
        return r;
    endfunction

    assign cfg_ready = 1'b1;

    assign out_free  = !out_valid_reg || !out_stall;
    assign s1_move   = s1_valid_reg && out_free;
    assign in_stall  = s1_valid_reg && !out_free;
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        cols_eff   = eff_count(cols_reg);
        rows_eff   = eff_count(rows_reg);
        outer_cur  = first_of_frame ? '0 : outer_reg;
        inner_cur  = first_of_frame ? '0 : inner_reg;
        inner_wrap = ((CNT_W + 1)'(inner_cur) + (CNT_W + 1)'(1)) >= (CNT_W + 1)'(rows_eff);
        outer_wrap = ((CNT_W + 1)'(outer_cur) + (CNT_W + 1)'(1)) >= (CNT_W + 1)'(cols_eff);
        px = $signed(P_W'({outer_cur, 1'b0}) - P_W'(cols_eff));
        py = $signed(P_W'({inner_cur, 1'b0}) - P_W'(rows_eff));
        outer_next = outer_reg;
        inner_next = inner_reg;
        if (in_accept)
        begin
            if (inner_wrap)
            begin
                inner_next = '0;
                outer_next = outer_wrap ? '0 : outer_cur + IDX_W'(1);
            end
            else
            begin
                inner_next = inner_cur + IDX_W'(1);
                outer_next = outer_cur;
            end
        end
    end

    always_comb
    begin
        pt[0] = PT_W'(s1_px_reg);
        pt[1] = PT_W'(s1_py_reg);
        pt[2] = PT_W'(s1_h_reg);
        pt[3] = PT_W'(1);
        sum_x = '0;
        sum_y = '0;
        for (int n = 0; n < LANES; n++)
        begin
            cx[n]     = $signed(x_coef_reg[COEF_W*n +: COEF_W]);
            cy[n]     = $signed(y_coef_reg[COEF_W*n +: COEF_W]);
            prod_x[n] = cx[n] * pt[n];
            prod_y[n] = cy[n] * pt[n];
            sum_x     = sum_x + SUM_W'(prod_x[n]);
            sum_y     = sum_y + SUM_W'(prod_y[n]);
        end
        vis = (sum_x > 0) && (sum_x < W_LIM) && (sum_y > 0) && (sum_y < H_LIM);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_coef_reg <= X_COEF_RESET;
            y_coef_reg <= Y_COEF_RESET;
            cols_reg   <= COUNT_RESET;
            rows_reg   <= COUNT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_X_COEF:    x_coef_reg <= cfg_data;
                CFG_Y_COEF:    y_coef_reg <= cfg_data;
                CFG_GRID_COLS: cols_reg   <= cfg_data[CFG_CNT_W-1:0];
                CFG_GRID_ROWS: rows_reg   <= cfg_data[CFG_CNT_W-1:0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outer_reg     <= '0;
            inner_reg     <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            outer_reg <= outer_next;
            inner_reg <= inner_next;
            if (in_accept)
                s1_valid_reg <= 1'b1;
            else if (s1_move)
                s1_valid_reg <= 1'b0;
            if (s1_move)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_px_reg   <= px;
            s1_py_reg   <= py;
            s1_h_reg    <= height;
            s1_last_reg <= inner_wrap && outer_wrap;
        end
        if (s1_move)
        begin
            pixel_x_reg   <= vis ? sum_x[COEF_FRACTION_BITS +: PIX_W] : '0;
            pixel_y_reg   <= vis ? sum_y[COEF_FRACTION_BITS +: PIX_W] : '0;
            visible_reg   <= vis;
            frame_end_reg <= s1_last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign pixel_x   = pixel_x_reg;
    assign pixel_y   = pixel_y_reg;
    assign visible   = visible_reg;
    assign frame_end = frame_end_reg;

`ifndef SYNTHESIS
    a_hidden_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !visible) |-> (pixel_x == '0 && pixel_y == '0))
        else $error("hidden point carries a nonzero position");

    a_stall_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg))
        else $error("input stalled with a free stage");

    a_first_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && first_of_frame && rows_eff > CNT_W'(1))
        |=> (inner_reg == IDX_W'(1) && outer_reg == '0))
        else $error("first item did not restart the grid");
`endif

endmodule
